### hdl/ioihr_pkg.sv
// Shared types, sizes and codes for the inter-onset-interval histogram block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ioihr_pkg;
  localparam int NUM_BINS    = 200;
  localparam int ONSET_DEPTH = 64;

  localparam int BIN_W     = $clog2(NUM_BINS);
  localparam int RING_AW   = $clog2(ONSET_DEPTH);
  localparam int KEPT_W    = $clog2(ONSET_DEPTH + 1);
  localparam int TIME_W    = 32;
  localparam int BIN_IDX_W = 8;
  localparam int COEF_W    = 16;
  localparam int HIST_W    = 32;
  localparam int CNT_W     = 7;
  localparam int C_W       = 15;                  // coefficient never exceeds 2^14
  localparam int SUM_W     = HIST_W + BIN_W;
  localparam int NUM_W     = SUM_W + C_W;
  localparam int DVD_W     = NUM_W;
  localparam int QUO_W     = 16;
  localparam int NB_W      = 5;
  localparam int LIM_W     = COEF_W + BIN_W + 1;
  localparam int P_W       = BIN_IDX_W + 1;
  localparam int M_W       = BIN_IDX_W;
  localparam int MP_W      = HIST_W + C_W;
  localparam int LP_W      = HIST_W + COEF_W;
  localparam int FP_W      = COEF_W + CNT_W;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [NB_W-1:0]  FILL_QB = NB_W'(BIN_W);
  localparam logic [NB_W-1:0]  COEF_QB = NB_W'(C_W);

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_BIN_WIDTH = 2'd0;
  localparam cfg_idx_t CFG_LEAK      = 2'd1;
  localparam cfg_idx_t CFG_FILL      = 2'd2;

  localparam logic [COEF_W-1:0] BIN_WIDTH_RST = 16'd240;
  localparam logic [COEF_W-1:0] LEAK_RST      = 16'd50197;
  localparam logic [COEF_W-1:0] FILL_RST      = 16'd20026;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ON_LIM, ST_ON_RRD, ST_ON_GAP, ST_ON_DIV, ST_ON_FWR, ST_ON_STORE,
    ST_LK_RD, ST_LK_MUL, ST_LK_WR,
    ST_RD_ISS, ST_RD_DIV, ST_RD_MUL, ST_RD_ACC, ST_RD_FIN, ST_RD_FDIV, ST_RESULT
  } state_e;
endpackage
`default_nettype wire

### hdl/ioihr_in_if.sv
// Command channel: valid/ready plus command payload.
// Depends on ioihr_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface ioihr_in_if;
  logic                             valid;
  logic                             ready;
  logic                             cmd;
  logic [ioihr_pkg::TIME_W-1:0]     onset_time;
  logic [ioihr_pkg::BIN_IDX_W-1:0]  bin_index;
  modport source (output valid, cmd, onset_time, bin_index, input ready);
  modport sink   (input valid, cmd, onset_time, bin_index, output ready);
endinterface
`default_nettype wire

### hdl/ioihr_out_if.sv
// Result channel: valid/ready plus remainder-error payload.
// Depends on ioihr_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface ioihr_out_if;
  logic                             valid;
  logic                             ready;
  logic [15:0]                      error_value;
  logic                             error_valid;
  logic [ioihr_pkg::BIN_IDX_W-1:0]  bin_echo;
  modport source (output valid, error_value, error_valid, bin_echo, input ready);
  modport sink   (input valid, error_value, error_valid, bin_echo, output ready);
endinterface
`default_nettype wire

### hdl/ioi_histogram_remainder_error.sv
// Onset: a walk over the kept onsets, then a leak pass over all bins (the divider takes one
//   quotient bit per cycle; the leak pass is one read-multiply-write of the histogram RAM per bin).
// Read: one coefficient division per bin, then one final division.
// One command at a time; a finished result waits in the output register while the next
//   command is taken. Reset clears control state and entry valid bits; no clearing pass.
// Depends on ioihr_pkg, ioihr_in_if, ioihr_out_if, ioihr_ram, ioihr_div.
`timescale 1ns / 1ps
`default_nettype none
module ioi_histogram_remainder_error (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  ioihr_in_if.sink                   in_ch,
  ioihr_out_if.source                out_ch,
  input  wire logic                  cfg_we_i,
  input  wire ioihr_pkg::cfg_idx_t   cfg_idx_i,
  input  wire logic [15:0]           cfg_data_i
);
  localparam int NB = ioihr_pkg::NUM_BINS;
  localparam logic [ioihr_pkg::BIN_W-1:0] LAST_BIN = ioihr_pkg::BIN_W'(NB - 1);
  localparam logic [ioihr_pkg::RING_AW-1:0] LAST_SLOT =
    ioihr_pkg::RING_AW'(ioihr_pkg::ONSET_DEPTH - 1);

  ioihr_pkg::state_e state_q, state_d;

  // configuration
  logic [15:0] bw_q, leak_q, fillc_q;

  // control
  logic [ioihr_pkg::KEPT_W-1:0]  kept_q, i_q;
  logic [ioihr_pkg::RING_AW-1:0] ptr_q;
  logic [ioihr_pkg::BIN_W-1:0]   k_q, fidx_q;
  logic [NB-1:0]                 hist_vld_q, fill_vld_q;
  logic                          ov_q;

  // payload
  logic [ioihr_pkg::TIME_W-1:0]    now_q;
  logic [15:0]                     w_q;
  logic [ioihr_pkg::LIM_W-1:0]     lim_q;
  logic [ioihr_pkg::P_W-1:0]       p_q, r_q;
  logic [ioihr_pkg::SUM_W-1:0]     sum_q;
  logic [ioihr_pkg::NUM_W-1:0]     num_q;
  logic [ioihr_pkg::LP_W-1:0]      lprod_q;
  logic [ioihr_pkg::FP_W-1:0]      fprod_q;
  logic [ioihr_pkg::MP_W-1:0]      mprod_q;
  logic [ioihr_pkg::BIN_IDX_W-1:0] bin_q, obin_q;
  logic [15:0]                     res_q, oval_q;
  logic                            res_ok_q, ook_q;

  // memory ports
  logic                            ring_we, ring_re;
  logic [ioihr_pkg::TIME_W-1:0]    ring_rd;
  logic                            fill_we, fill_re;
  logic [ioihr_pkg::BIN_W-1:0]     fill_wa, fill_ra;
  logic [ioihr_pkg::CNT_W-1:0]     fill_wd, fill_rd;
  logic                            hist_we, hist_re;
  logic [ioihr_pkg::HIST_W-1:0]    hist_wd, hist_rd;

  // divider
  logic                            div_start, div_idle;
  logic [ioihr_pkg::DVD_W-1:0]     div_dvd, div_dsr;
  logic [ioihr_pkg::NB_W-1:0]      div_nb;
  logic [ioihr_pkg::QUO_W-1:0]     div_quot;

  // datapath terms
  logic [ioihr_pkg::TIME_W-1:0]    gap;
  logic                            gap_in;
  logic [ioihr_pkg::CNT_W-1:0]     cnt_rmw, cnt_lk;
  logic [ioihr_pkg::HIST_W-1:0]    hv;
  logic [ioihr_pkg::HIST_W:0]      leak_sum;
  logic [ioihr_pkg::P_W-1:0]       p_minus_r;
  logic [ioihr_pkg::M_W-1:0]       m_val;
  logic [2*ioihr_pkg::M_W-1:0]     m_sq;
  logic [2*ioihr_pkg::P_W-1:0]     p_sq;
  logic                            last_iv, out_load;

  assign gap       = now_q - ring_rd;
  assign gap_in    = gap < ioihr_pkg::TIME_W'(lim_q);
  assign cnt_rmw   = fill_vld_q[fidx_q] ? fill_rd : '0;
  assign cnt_lk    = fill_vld_q[k_q] ? fill_rd : '0;
  assign hv        = hist_vld_q[k_q] ? hist_rd : '0;
  assign leak_sum  = (ioihr_pkg::HIST_W + 1)'(lprod_q[ioihr_pkg::LP_W-1:16])
                   + (ioihr_pkg::HIST_W + 1)'(fprod_q);
  assign p_minus_r = p_q - r_q;
  assign m_val     = ioihr_pkg::M_W'((r_q < p_minus_r) ? r_q : p_minus_r);
  // m is at most 128, so m*m fits in 15 bits of the double width
  assign m_sq      = (2*ioihr_pkg::M_W)'(m_val) * (2*ioihr_pkg::M_W)'(m_val);
  assign p_sq      = (2*ioihr_pkg::P_W)'(p_q) * (2*ioihr_pkg::P_W)'(p_q);
  assign last_iv   = (i_q + ioihr_pkg::KEPT_W'(1)) == kept_q;
  assign out_load  = (state_q == ioihr_pkg::ST_RESULT) && (!ov_q || out_ch.ready);

  assign in_ch.ready = (state_q == ioihr_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ioihr_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_d = in_ch.cmd ? ioihr_pkg::ST_RD_ISS : ioihr_pkg::ST_ON_LIM;
        end
      end
      ioihr_pkg::ST_ON_LIM:
        state_d = (kept_q == '0) ? ioihr_pkg::ST_ON_STORE : ioihr_pkg::ST_ON_RRD;
      ioihr_pkg::ST_ON_RRD: state_d = ioihr_pkg::ST_ON_GAP;
      ioihr_pkg::ST_ON_GAP: begin
        if (gap_in) begin
          state_d = ioihr_pkg::ST_ON_DIV;
        end else begin
          state_d = last_iv ? ioihr_pkg::ST_ON_STORE : ioihr_pkg::ST_ON_RRD;
        end
      end
      ioihr_pkg::ST_ON_DIV: if (div_idle) state_d = ioihr_pkg::ST_ON_FWR;
      ioihr_pkg::ST_ON_FWR:
        state_d = last_iv ? ioihr_pkg::ST_ON_STORE : ioihr_pkg::ST_ON_RRD;
      ioihr_pkg::ST_ON_STORE: state_d = ioihr_pkg::ST_LK_RD;
      ioihr_pkg::ST_LK_RD:    state_d = ioihr_pkg::ST_LK_MUL;
      ioihr_pkg::ST_LK_MUL:   state_d = ioihr_pkg::ST_LK_WR;
      ioihr_pkg::ST_LK_WR:
        state_d = (k_q == LAST_BIN) ? ioihr_pkg::ST_IDLE : ioihr_pkg::ST_LK_RD;
      ioihr_pkg::ST_RD_ISS: state_d = ioihr_pkg::ST_RD_DIV;
      ioihr_pkg::ST_RD_DIV: if (div_idle) state_d = ioihr_pkg::ST_RD_MUL;
      ioihr_pkg::ST_RD_MUL: state_d = ioihr_pkg::ST_RD_ACC;
      ioihr_pkg::ST_RD_ACC:
        state_d = (k_q == LAST_BIN) ? ioihr_pkg::ST_RD_FIN : ioihr_pkg::ST_RD_ISS;
      ioihr_pkg::ST_RD_FIN:
        state_d = (sum_q == '0) ? ioihr_pkg::ST_RESULT : ioihr_pkg::ST_RD_FDIV;
      ioihr_pkg::ST_RD_FDIV: if (div_idle) state_d = ioihr_pkg::ST_RESULT;
      ioihr_pkg::ST_RESULT: if (!ov_q || out_ch.ready) state_d = ioihr_pkg::ST_IDLE;
      default: state_d = ioihr_pkg::ST_IDLE;
    endcase
  end

  // memory strobes and divider operands
  always_comb begin
    ring_we   = 1'b0;
    ring_re   = 1'b0;
    fill_we   = 1'b0;
    fill_re   = 1'b0;
    fill_wa   = fidx_q;
    fill_ra   = k_q;
    fill_wd   = cnt_rmw + ioihr_pkg::CNT_W'(1);
    hist_we   = 1'b0;
    hist_re   = 1'b0;
    hist_wd   = leak_sum[ioihr_pkg::HIST_W] ? '1 : leak_sum[ioihr_pkg::HIST_W-1:0];
    div_start = 1'b0;
    div_dvd   = ioihr_pkg::DVD_W'(gap);
    div_dsr   = ioihr_pkg::DVD_W'(w_q);
    div_nb    = ioihr_pkg::FILL_QB;
    case (state_q)
      ioihr_pkg::ST_ON_RRD: ring_re = 1'b1;
      ioihr_pkg::ST_ON_GAP: div_start = gap_in;
      ioihr_pkg::ST_ON_DIV: begin
        fill_re = div_idle;
        fill_ra = div_quot[ioihr_pkg::BIN_W-1:0];
      end
      ioihr_pkg::ST_ON_FWR: fill_we = (cnt_rmw != ioihr_pkg::CNT_MAX);
      ioihr_pkg::ST_ON_STORE: ring_we = 1'b1;
      ioihr_pkg::ST_LK_RD: begin
        fill_re = 1'b1;
        hist_re = 1'b1;
      end
      ioihr_pkg::ST_LK_WR: begin
        hist_we = 1'b1;
        fill_we = 1'b1;
        fill_wa = k_q;
        fill_wd = '0;
      end
      ioihr_pkg::ST_RD_ISS: begin
        hist_re   = 1'b1;
        div_start = 1'b1;
        div_dvd   = ioihr_pkg::DVD_W'({m_sq, 16'd0});
        div_dsr   = ioihr_pkg::DVD_W'(p_sq);
        div_nb    = ioihr_pkg::COEF_QB;
      end
      ioihr_pkg::ST_RD_FIN: begin
        div_start = (sum_q != '0);
        div_dvd   = num_q;
        div_dsr   = ioihr_pkg::DVD_W'(sum_q);
        div_nb    = ioihr_pkg::COEF_QB;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ioihr_pkg::ST_IDLE;
      bw_q       <= ioihr_pkg::BIN_WIDTH_RST;
      leak_q     <= ioihr_pkg::LEAK_RST;
      fillc_q    <= ioihr_pkg::FILL_RST;
      kept_q     <= '0;
      ptr_q      <= '0;
      i_q        <= '0;
      k_q        <= '0;
      hist_vld_q <= '0;
      fill_vld_q <= '0;
      ov_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ioihr_pkg::CFG_BIN_WIDTH: bw_q    <= cfg_data_i;
          ioihr_pkg::CFG_LEAK:      leak_q  <= cfg_data_i;
          ioihr_pkg::CFG_FILL:      fillc_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        i_q <= '0;
        k_q <= '0;
      end
      if ((state_q == ioihr_pkg::ST_ON_GAP && !gap_in) || state_q == ioihr_pkg::ST_ON_FWR) begin
        i_q <= i_q + ioihr_pkg::KEPT_W'(1);
      end
      if (ring_we) begin
        ptr_q <= (ptr_q == LAST_SLOT) ? '0 : ptr_q + ioihr_pkg::RING_AW'(1);
        if (kept_q != ioihr_pkg::KEPT_W'(ioihr_pkg::ONSET_DEPTH)) begin
          kept_q <= kept_q + ioihr_pkg::KEPT_W'(1);
        end
        k_q <= '0;
      end
      if (state_q == ioihr_pkg::ST_LK_WR || state_q == ioihr_pkg::ST_RD_ACC) begin
        k_q <= k_q + ioihr_pkg::BIN_W'(1);
      end
      if (hist_we) hist_vld_q[k_q] <= 1'b1;
      if (fill_we) fill_vld_q[fill_wa] <= 1'b1;
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_ch.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      now_q <= in_ch.onset_time;
      w_q   <= (bw_q == '0) ? 16'd1 : bw_q;
      bin_q <= in_ch.bin_index;
      p_q   <= ioihr_pkg::P_W'(in_ch.bin_index) + ioihr_pkg::P_W'(1);
      r_q   <= (in_ch.bin_index == '0) ? '0 : ioihr_pkg::P_W'(1);
      sum_q <= '0;
      num_q <= '0;
    end
    if (state_q == ioihr_pkg::ST_ON_LIM) begin
      lim_q <= ioihr_pkg::LIM_W'(w_q) * ioihr_pkg::LIM_W'(NB);
    end
    if (fill_re && state_q == ioihr_pkg::ST_ON_DIV) begin
      fidx_q <= div_quot[ioihr_pkg::BIN_W-1:0];
    end
    if (state_q == ioihr_pkg::ST_LK_MUL) begin
      lprod_q <= ioihr_pkg::LP_W'(leak_q) * ioihr_pkg::LP_W'(hv);
      fprod_q <= ioihr_pkg::FP_W'(fillc_q) * ioihr_pkg::FP_W'(cnt_lk);
    end
    if (state_q == ioihr_pkg::ST_RD_MUL) begin
      mprod_q <= ioihr_pkg::MP_W'(hv) * ioihr_pkg::MP_W'(div_quot[ioihr_pkg::C_W-1:0]);
    end
    if (state_q == ioihr_pkg::ST_RD_ACC) begin
      sum_q <= sum_q + ioihr_pkg::SUM_W'(hv);
      num_q <= num_q + ioihr_pkg::NUM_W'(mprod_q);
      r_q   <= ((r_q + ioihr_pkg::P_W'(1)) == p_q) ? '0 : r_q + ioihr_pkg::P_W'(1);
    end
    if (state_q == ioihr_pkg::ST_RD_FIN) begin
      res_q    <= '0;
      res_ok_q <= (sum_q != '0);
    end
    if (state_q == ioihr_pkg::ST_RD_FDIV && div_idle) begin
      res_q <= div_quot;
    end
    if (out_load) begin
      oval_q <= res_q;
      ook_q  <= res_ok_q;
      obin_q <= bin_q;
    end
  end

  assign out_ch.valid       = ov_q;
  assign out_ch.error_value = oval_q;
  assign out_ch.error_valid = ook_q;
  assign out_ch.bin_echo    = obin_q;

  ioihr_ram #(.WIDTH(ioihr_pkg::TIME_W), .DEPTH(ioihr_pkg::ONSET_DEPTH)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ptr_q),
    .wdata_i (now_q),
    .re_i    (ring_re),
    .raddr_i (i_q[ioihr_pkg::RING_AW-1:0]),
    .rdata_o (ring_rd)
  );

  ioihr_ram #(.WIDTH(ioihr_pkg::CNT_W), .DEPTH(NB)) u_fill (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (fill_wa),
    .wdata_i (fill_wd),
    .re_i    (fill_re),
    .raddr_i (fill_ra),
    .rdata_o (fill_rd)
  );

  ioihr_ram #(.WIDTH(ioihr_pkg::HIST_W), .DEPTH(NB)) u_hist (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (k_q),
    .wdata_i (hist_wd),
    .re_i    (hist_re),
    .raddr_i (k_q),
    .rdata_o (hist_rd)
  );

  ioihr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .nbits_i    (div_nb),
    .idle_o     (div_idle),
    .quot_o     (div_quot)
  );

  // divider is never restarted mid-operation
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> div_idle) else $error("divider started while busy");

  a_kept_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= ioihr_pkg::KEPT_W'(ioihr_pkg::ONSET_DEPTH)) else $error("kept count overflow");

  // new onset stored only after every kept onset was visited
  a_ring_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_we |-> (i_q == kept_q)) else $error("onset stored before interval walk ended");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> ov_q) else $error("result lost at output register");
endmodule
`default_nettype wire

### hdl/ioihr_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ioihr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

### hdl/ioihr_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on ioihr_pkg. Caller guarantees dividend < divisor * 2^nbits.
`timescale 1ns / 1ps
`default_nettype none
module ioihr_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [ioihr_pkg::DVD_W-1:0]   dividend_i,
  input  wire logic [ioihr_pkg::DVD_W-1:0]   divisor_i,
  input  wire logic [ioihr_pkg::NB_W-1:0]    nbits_i,
  output logic                               idle_o,
  output logic      [ioihr_pkg::QUO_W-1:0]   quot_o
);
  logic [ioihr_pkg::DVD_W-1:0] rem_q, dsr_q;
  logic [ioihr_pkg::QUO_W-1:0] quot_q;
  logic [ioihr_pkg::NB_W-1:0]  cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= nbits_i;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - ioihr_pkg::NB_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      dsr_q  <= divisor_i << (nbits_i - ioihr_pkg::NB_W'(1));
      quot_q <= '0;
    end else if (cnt_q != '0) begin
      if (rem_q >= dsr_q) begin
        rem_q  <= rem_q - dsr_q;
        quot_q <= {quot_q[ioihr_pkg::QUO_W-2:0], 1'b1};
      end else begin
        quot_q <= {quot_q[ioihr_pkg::QUO_W-2:0], 1'b0};
      end
      dsr_q <= dsr_q >> 1;
    end
  end

  assign idle_o = (cnt_q == '0);
  assign quot_o = quot_q;
endmodule
`default_nettype wire

### bench/testbench.sv
// Self-checking bench for ioi_histogram_remainder_error: random onset/read traffic with
// idling on both channels, checked against an in-bench histogram predictor.
// Depends on ioihr_pkg, ioihr_in_if, ioihr_out_if and the block under test.
`timescale 1ns / 1ps
module testbench;
  localparam logic CMD_ONSET = 1'b0;
  localparam logic CMD_READ  = 1'b1;
  // Settle time after the last result
  localparam int SETTLE_CYC  = 1500;
  localparam longint CYC_LIMIT = 12_000_000;

  typedef struct packed {
    logic [15:0]                     value;
    logic                            ok;
    logic [ioihr_pkg::BIN_IDX_W-1:0] bin;
  } err_res_t;

  // Scoreboard: models the histogram and holds the pending read results
  class ioi_scoreboard;
    logic [15:0] bin_w, leak, fill;
    logic [ioihr_pkg::TIME_W-1:0] ring [ioihr_pkg::ONSET_DEPTH];
    int unsigned kept, wptr;
    logic [ioihr_pkg::HIST_W-1:0] hist [ioihr_pkg::NUM_BINS];
    err_res_t pending_errs [$];
    int unsigned mismatches;

    function new();
      bin_w = ioihr_pkg::BIN_WIDTH_RST;
      leak  = ioihr_pkg::LEAK_RST;
      fill  = ioihr_pkg::FILL_RST;
      kept = 0;
      wptr = 0;
      mismatches = 0;
      foreach (hist[i]) hist[i] = '0;
      foreach (ring[i]) ring[i] = '0;
    endfunction

    function void set_reg(ioihr_pkg::cfg_idx_t idx, logic [15:0] val);
      case (idx)
        ioihr_pkg::CFG_BIN_WIDTH: bin_w = val;
        ioihr_pkg::CFG_LEAK:      leak  = val;
        ioihr_pkg::CFG_FILL:      fill  = val;
        default: ;
      endcase
    endfunction

    function void add_onset(logic [ioihr_pkg::TIME_W-1:0] t);
      int unsigned w, idx;
      int unsigned cnt [ioihr_pkg::NUM_BINS];
      logic [ioihr_pkg::TIME_W-1:0] gap;
      longint unsigned h;
      w = (bin_w == 0) ? 1 : bin_w;
      foreach (cnt[i]) cnt[i] = 0;
      for (int i = 0; i < kept; i++) begin
        gap = t - ring[i];
        idx = gap / w;
        if (idx < ioihr_pkg::NUM_BINS && cnt[idx] < 127) cnt[idx]++;
      end
      ring[wptr] = t;
      wptr = (wptr + 1) % ioihr_pkg::ONSET_DEPTH;
      if (kept < ioihr_pkg::ONSET_DEPTH) kept++;
      for (int i = 0; i < ioihr_pkg::NUM_BINS; i++) begin
        h = (longint'(leak) * hist[i]) >> 16;
        h += longint'(fill) * cnt[i];
        hist[i] = (h > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : h[31:0];
      end
    endfunction

    function err_res_t remainder_error(logic [ioihr_pkg::BIN_IDX_W-1:0] b);
      longint unsigned p, r, m, c, total, num;
      err_res_t res;
      p = b + 1;
      total = 0;
      num = 0;
      for (int k = 0; k < ioihr_pkg::NUM_BINS; k++) begin
        r = (k + 1) % p;
        m = (r < p - r) ? r : p - r;
        c = (m * m * 65536) / (p * p);
        total += hist[k];
        num += longint'(hist[k]) * c;
      end
      res.bin = b;
      if (total == 0) begin
        res.value = '0;
        res.ok = 1'b0;
      end else begin
        res.value = 16'(num / total);
        res.ok = 1'b1;
      end
      return res;
    endfunction

    // Appends one expected result at the tail of the pending queue
    function void enqueue_err(err_res_t res);
      pending_errs = {pending_errs, res};
    endfunction

    // Called on each accepted command transfer
    function void note_cmd(logic cmd, logic [ioihr_pkg::TIME_W-1:0] t,
                           logic [ioihr_pkg::BIN_IDX_W-1:0] b);
      if (cmd == CMD_ONSET) add_onset(t);
      else enqueue_err(remainder_error(b));
    endfunction

    // Called on each accepted result transfer
    function void check_result(err_res_t got);
      err_res_t want;
      if (pending_errs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %h valid %b bin %0d",
                   got.value, got.ok, got.bin);
        return;
      end
      want = pending_errs.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("bin %0d: expected value %h valid %b echo %0d, got %h %b %0d",
                   want.bin, want.value, want.ok, want.bin, got.value, got.ok, got.bin);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  ioihr_pkg::cfg_idx_t cfg_idx_i = ioihr_pkg::CFG_BIN_WIDTH;
  logic [15:0] cfg_data_i = '0;

  ioihr_in_if  in_ch();
  ioihr_out_if out_ch();

  ioi_histogram_remainder_error DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  ioi_scoreboard sb = new();
  bit calm;          // when set, neither side idles
  longint cycles = 0;
  logic [ioihr_pkg::TIME_W-1:0] now_t;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: random stalls before each transfer
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = calm ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      sb.check_result('{out_ch.error_value, out_ch.error_valid, out_ch.bin_echo});
    end
  end

  // One command transfer; entered and left at a falling edge
  task automatic send_cmd(logic cmd, logic [ioihr_pkg::TIME_W-1:0] t,
                          logic [ioihr_pkg::BIN_IDX_W-1:0] b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.cmd = cmd;
    in_ch.onset_time = t;
    in_ch.bin_index = b;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_cmd(cmd, t, b);
    @(negedge clk_i);
  endtask

  // Sender pause: all results in, then room for a trailing onset to finish
  task automatic drain();
    in_ch.valid = 1'b0;
    while (sb.pending_errs.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_regs(logic [15:0] bw, logic [15:0] lk, logic [15:0] fl);
    cfg_we_i = 1'b1;
    cfg_idx_i = ioihr_pkg::CFG_BIN_WIDTH; cfg_data_i = bw;
    @(negedge clk_i);
    cfg_idx_i = ioihr_pkg::CFG_LEAK;      cfg_data_i = lk;
    @(negedge clk_i);
    cfg_idx_i = ioihr_pkg::CFG_FILL;      cfg_data_i = fl;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_reg(ioihr_pkg::CFG_BIN_WIDTH, bw);
    sb.set_reg(ioihr_pkg::CFG_LEAK, lk);
    sb.set_reg(ioihr_pkg::CFG_FILL, fl);
  endtask

  // Mostly steady onset trains with gaps that land in the histogram, mixed with reads;
  // a few out-of-order or wild onset times as noise
  task automatic random_phase(int n);
    int unsigned span, sel;
    span = ((sb.bin_w == 0) ? 1 : sb.bin_w) * ioihr_pkg::NUM_BINS / 3;
    for (int i = 0; i < n; i++) begin
      calm = (i < 25);
      sel = $urandom_range(0, 99);
      if (sel < 35)
        send_cmd(CMD_READ, $urandom,
                 ioihr_pkg::BIN_IDX_W'((sel < 5) ? $urandom_range(200, 255)
                                      : $urandom_range(0, ioihr_pkg::NUM_BINS - 1)));
      else if (sel < 40)
        send_cmd(CMD_ONSET, now_t - $urandom_range(1, span),
                 ioihr_pkg::BIN_IDX_W'($urandom));
      else if (sel < 42)
        send_cmd(CMD_ONSET, $urandom, ioihr_pkg::BIN_IDX_W'($urandom));
      else begin
        now_t += $urandom_range(0, span);
        send_cmd(CMD_ONSET, now_t, ioihr_pkg::BIN_IDX_W'($urandom));
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_ONSET;
    in_ch.onset_time = '0;
    in_ch.bin_index = '0;
    calm = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty histogram, zero gaps, wrapped and decreasing times, extreme bins
    send_cmd(CMD_READ, '0, 8'd0);
    send_cmd(CMD_READ, '1, 8'd255);
    send_cmd(CMD_ONSET, 32'd0, '0);
    send_cmd(CMD_ONSET, 32'd0, '1);
    send_cmd(CMD_READ, '0, 8'd0);
    send_cmd(CMD_ONSET, 32'd480, '0);
    send_cmd(CMD_ONSET, 32'hFFFF_FFFF, '0);
    send_cmd(CMD_ONSET, 32'd1000, '0);
    send_cmd(CMD_ONSET, 32'd1240, '0);
    send_cmd(CMD_ONSET, 32'd48_000, '0);
    for (int b = 0; b < 4; b++) send_cmd(CMD_READ, '0, 8'(b));
    send_cmd(CMD_READ, '0, 8'd199);
    send_cmd(CMD_READ, '0, 8'd200);
    send_cmd(CMD_READ, '0, 8'd255);
    send_cmd(CMD_READ, '0, 8'hAA);
    send_cmd(CMD_READ, '0, 8'h55);

    now_t = $urandom;
    random_phase(140);
    drain();
    write_regs(16'd1, 16'hFFFF, 16'hFFFF);   // saturating, slowest leak
    random_phase(130);
    drain();
    write_regs(16'd0, 16'd0, 16'd1);         // zero width acts as one; full leak
    random_phase(130);
    drain();
    write_regs(16'hFFFF, 16'h8000, ioihr_pkg::FILL_RST);
    random_phase(130);
    drain();
    write_regs(16'($urandom_range(1, 600)), 16'($urandom), 16'($urandom));
    random_phase(130);
    drain();

    if (sb.mismatches == 0 && sb.pending_errs.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
